FILE: hw/rtl/cei_pkg.sv
package cei_pkg;

   // Internal fixed-point format: unsigned, FB fraction bits in 64 bits
   localparam int FB = 48;
   localparam int ITERATIONS = 8;
   localparam int ITER_W = (ITERATIONS > 1) ? $clog2(ITERATIONS) : 1;

   // Bit-serial steps of the square root and divide
   localparam int STEPS = 64;
   localparam int CNT_W = $clog2(STEPS);

   localparam logic [63:0] ONE_Q = 64'd1 << FB;
   localparam logic [63:0] ALL_ONES = {64{1'b1}};
   localparam logic [63:0] SUM_LIMIT = 64'd1 << 62;

   // pi/2 in Q2.62, truncated to FB fraction bits, split as a 128-bit dividend
   localparam logic [63:0] PI_HALF_Q = 64'h6487ED5110B4611A >> (62 - FB);
   localparam logic [63:0] NUM_HI = PI_HALF_Q >> (64 - FB);
   localparam logic [63:0] NUM_LO = PI_HALF_Q << FB;

   // Arithmetic unit operations
   localparam logic [1:0] OP_MUL = 2'd0;
   localparam logic [1:0] OP_SQRT = 2'd1;
   localparam logic [1:0] OP_DIV = 2'd2;

   typedef struct packed {
      logic        start;
      logic [1:0]  op;
      logic [63:0] x;
      logic [63:0] y;
   } cei_cmd_type;

   typedef struct packed {
      logic        done;
      logic [63:0] result;
   } cei_res_type;

endpackage

FILE: hw/rtl/cei_arith.sv
module cei_arith
   import cei_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  cei_cmd_type cmd,
   output cei_res_type res
);

   logic             busy_ff, busy_in;
   logic [1:0]       op_ff, op_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [63:0]      x_ff, x_in;
   logic [63:0]      y_ff, y_in;
   logic [127:0]     acc_ff, acc_in;
   logic [63:0]      pp_ff, pp_in;
   logic [127:0]     work_ff, work_in;
   logic [67:0]      rem_ff, rem_in;
   logic [63:0]      root_ff, root_in;
   logic             done_ff, done_in;
   logic [63:0]      result_ff, result_in;

   // Multiply: partial product select and accumulate shift
   logic [1:0]   prev_sel;
   logic [31:0]  x_half, y_half;
   logic [7:0]   pp_shamt;
   logic [127:0] acc_sum;

   assign x_half = cnt_ff[1] ? x_ff[63:32] : x_ff[31:0];
   assign y_half = cnt_ff[0] ? y_ff[63:32] : y_ff[31:0];
   assign prev_sel = cnt_ff[1:0] - 2'd1;
   assign pp_shamt = {1'b0, prev_sel[1] & prev_sel[0], prev_sel[1] ^ prev_sel[0], 5'b0};
   assign acc_sum = acc_ff + (128'(pp_ff) << pp_shamt);

   // Square root: one result bit per step
   logic [67:0] sq_rem, sq_trial;
   logic        sq_ge;

   assign sq_rem = {rem_ff[65:0], work_ff[127:126]};
   assign sq_trial = {2'b0, root_ff, 2'b01};
   assign sq_ge = sq_rem >= sq_trial;

   // Divide: one quotient bit per step
   logic [64:0] dv_rem;
   logic        dv_ge;
   logic [64:0] dv_diff;

   assign dv_rem = {rem_ff[63:0], work_ff[127]};
   assign dv_ge = dv_rem >= {1'b0, x_ff};
   assign dv_diff = dv_rem - {1'b0, x_ff};

   always_comb begin
      busy_in = busy_ff;
      op_in = op_ff;
      cnt_in = cnt_ff;
      x_in = x_ff;
      y_in = y_ff;
      acc_in = acc_ff;
      pp_in = pp_ff;
      work_in = work_ff;
      rem_in = rem_ff;
      root_in = root_ff;
      done_in = 1'b0;
      result_in = result_ff;

      if (cmd.start) begin
         // Load operands and start
         busy_in = 1'b1;
         op_in = cmd.op;
         cnt_in = '0;
         x_in = cmd.x;
         y_in = cmd.y;
         acc_in = '0;
         rem_in = '0;
         root_in = '0;
         work_in = 128'(cmd.x) << FB;
         if (cmd.op == OP_DIV) begin
            rem_in = 68'(NUM_HI);
            work_in = {NUM_LO, 64'b0};
            // Quotient does not fit: saturate at once
            if (cmd.x == 64'd0 || NUM_HI >= cmd.x) begin
               busy_in = 1'b0;
               done_in = 1'b1;
               result_in = ALL_ONES;
            end
         end
      end else if (busy_ff) begin
         cnt_in = cnt_ff + 1'b1;
         case (op_ff)
            OP_MUL: begin
               if (cnt_ff < CNT_W'(4)) begin
                  pp_in = {32'b0, x_half} * {32'b0, y_half};
               end
               if (cnt_ff != '0) begin
                  acc_in = acc_sum;
               end
               if (cnt_ff == CNT_W'(4)) begin
                  busy_in = 1'b0;
                  done_in = 1'b1;
                  result_in = (acc_sum[127:64+FB] != '0) ? ALL_ONES : acc_sum[63+FB:FB];
               end
            end
            OP_SQRT: begin
               rem_in = sq_ge ? (sq_rem - sq_trial) : sq_rem;
               root_in = {root_ff[62:0], sq_ge};
               work_in = work_ff << 2;
               if (cnt_ff == CNT_W'(STEPS - 1)) begin
                  busy_in = 1'b0;
                  done_in = 1'b1;
                  result_in = {root_ff[62:0], sq_ge};
               end
            end
            OP_DIV: begin
               rem_in = 68'(dv_ge ? dv_diff[63:0] : dv_rem[63:0]);
               root_in = {root_ff[62:0], dv_ge};
               work_in = work_ff << 1;
               if (cnt_ff == CNT_W'(STEPS - 1)) begin
                  busy_in = 1'b0;
                  done_in = 1'b1;
                  result_in = {root_ff[62:0], dv_ge};
               end
            end
            default: begin
               busy_in = 1'b0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      op_ff <= op_in;
      cnt_ff <= cnt_in;
      x_ff <= x_in;
      y_ff <= y_in;
      acc_ff <= acc_in;
      pp_ff <= pp_in;
      work_ff <= work_in;
      rem_ff <= rem_in;
      root_ff <= root_in;
      result_ff <= result_in;
   end

   assign res.done = done_ff;
   assign res.result = result_ff;

   // A new command never lands on a running operation
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> !cmd.start)
      else $error("command issued while unit busy");

   // Done only after work
   a_done_after_busy: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> $past(busy_ff) || $past(cmd.start))
      else $error("done without an operation");

   // The unit idles the cycle it reports
   a_done_idle: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> !busy_ff)
      else $error("unit still busy at done");

endmodule

FILE: hw/rtl/complete_elliptic_integrals.sv
// Channel   Direction  Ports                                   Item
// req       in         req_valid, req_stall, req_param_m       parameter m, signed Q2.30
// rsp       out        rsp_valid, rsp_stall, rsp_k_value,      K(m), E(m) in Q5.27, flags
//                      rsp_e_value, rsp_k_domain_error,
//                      rsp_e_domain_error
//
// Each of the 8 passes runs six 64-bit multiplies and two 64-step square roots on the
// one shared arithmetic unit, plus two roots at the start and a multiply, a 64-step
// divide and a multiply at the end.
// An item with m >= 1 skips the arithmetic unit and goes straight to the done state.
// Reset is synchronous and active high and clears the sequencer and the output valid.
// req_stall is high from acceptance until the result is loaded into the output register;
// a waiting result does not block the next item until that item completes.
module complete_elliptic_integrals
   import cei_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [31:0] req_param_m,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_k_value,
   output logic [31:0] rsp_e_value,
   output logic        rsp_k_domain_error,
   output logic        rsp_e_domain_error
);

   localparam logic [3:0] ST_IDLE = 4'd0;
   localparam logic [3:0] ST_OM1  = 4'd1;
   localparam logic [3:0] ST_OM2  = 4'd2;
   localparam logic [3:0] ST_AA   = 4'd3;
   localparam logic [3:0] ST_BB   = 4'd4;
   localparam logic [3:0] ST_P    = 4'd5;
   localparam logic [3:0] ST_Q    = 4'd6;
   localparam logic [3:0] ST_AB   = 4'd7;
   localparam logic [3:0] ST_ABS  = 4'd8;
   localparam logic [3:0] ST_R1   = 4'd9;
   localparam logic [3:0] ST_R2   = 4'd10;
   localparam logic [3:0] ST_A2   = 4'd11;
   localparam logic [3:0] ST_DIV  = 4'd12;
   localparam logic [3:0] ST_E    = 4'd13;
   localparam logic [3:0] ST_DONE = 4'd14;

   localparam logic signed [64:0] SUM_HI = signed'({1'b0, SUM_LIMIT});
   localparam logic signed [64:0] SUM_LO = -SUM_HI;

   logic [3:0]        state_ff, state_in;
   logic              go_ff, go_in;
   logic [ITER_W-1:0] iter_ff, iter_in;
   logic [63:0]       a_ff, a_in;
   logic [63:0]       b_ff, b_in;
   logic [63:0]       aa_ff, aa_in;
   logic [63:0]       s_ff, s_in;
   logic [63:0]       p_ff, p_in;
   logic [63:0]       t_ff, t_in;
   logic [63:0]       k_ff, k_in;
   logic [63:0]       e_ff, e_in;
   logic signed [64:0] sum_ff, sum_in;
   logic              kerr_ff, kerr_in;
   logic              eerr_ff, eerr_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [31:0]       rsp_k_ff, rsp_k_in;
   logic [31:0]       rsp_e_ff, rsp_e_in;
   logic              rsp_kerr_ff, rsp_kerr_in;
   logic              rsp_eerr_ff, rsp_eerr_in;

   cei_cmd_type cmd;
   cei_res_type res;

   cei_arith u_arith (
      .clock (clock),
      .reset (reset),
      .cmd   (cmd),
      .res   (res)
   );

   function automatic logic [31:0] to_out(input logic [63:0] v);
      to_out = (v[63:FB+5] != '0) ? 32'hFFFF_FFFF : v[FB+4:FB-27];
   endfunction

   // Decode m: 1 - m in Q2.30
   logic signed [33:0] om30;
   logic               om_le_zero;
   logic [63:0]        om_q;

   assign om30 = (34'sd1 <<< 30) - 34'(signed'(req_param_m));
   assign om_le_zero = om30[33] || (om30 == 34'sd0);
   assign om_q = 64'(om30[31:0]) << (FB - 30);

   // Sum term: 4^i * (a^4 - h^2), saturated
   logic              q_gt;
   logic [63:0]       mag, limit, mag_sh;
   logic [ITER_W:0]   sh;
   logic signed [64:0] sum_add, sum_sat;

   assign q_gt = res.result > p_ff;
   assign mag = q_gt ? (res.result - p_ff) : (p_ff - res.result);
   assign sh = {iter_ff, 1'b0};
   assign limit = SUM_LIMIT >> sh;
   assign mag_sh = (mag > limit) ? SUM_LIMIT : (mag << sh);
   assign sum_add = q_gt ? (sum_ff - signed'({1'b0, mag_sh}))
                         : (sum_ff + signed'({1'b0, mag_sh}));
   assign sum_sat = (sum_add > SUM_HI) ? SUM_HI : ((sum_add < SUM_LO) ? SUM_LO : sum_add);

   // Final factor 1 - sum, floored at zero
   logic signed [64:0] onem;
   logic [63:0]        f_q;
   logic [63:0]        a_next;

   assign onem = signed'({1'b0, ONE_Q}) - sum_ff;
   assign f_q = onem[64] ? 64'd0 : onem[63:0];
   assign a_next = (a_ff >> 1) + (b_ff >> 1) + {63'b0, a_ff[0] & b_ff[0]};

   // Select operands for the shared unit
   always_comb begin
      cmd.start = go_ff;
      cmd.op = OP_MUL;
      cmd.x = a_ff;
      cmd.y = a_ff;
      case (state_ff)
         ST_OM1, ST_OM2, ST_R1, ST_R2: begin
            cmd.op = OP_SQRT;
            cmd.x = (state_ff == ST_OM2 || state_ff == ST_R2 || state_ff == ST_R1 ||
                     state_ff == ST_OM1) ? t_ff : a_ff;
         end
         ST_BB: begin
            cmd.x = b_ff;
            cmd.y = b_ff;
         end
         ST_P: begin
            cmd.x = aa_ff;
            cmd.y = aa_ff;
         end
         ST_Q: begin
            cmd.x = s_ff >> 1;
            cmd.y = s_ff >> 1;
         end
         ST_AB: begin
            cmd.y = b_ff;
         end
         ST_ABS: begin
            cmd.x = t_ff;
            cmd.y = s_ff;
         end
         ST_DIV: begin
            cmd.op = OP_DIV;
            cmd.x = t_ff;
         end
         ST_E: begin
            cmd.x = k_ff;
            cmd.y = f_q;
         end
         default: begin
            cmd.op = OP_MUL;
         end
      endcase
   end

   // Sequence the passes
   always_comb begin
      state_in = state_ff;
      go_in = 1'b0;
      iter_in = iter_ff;
      a_in = a_ff;
      b_in = b_ff;
      aa_in = aa_ff;
      s_in = s_ff;
      p_in = p_ff;
      t_in = t_ff;
      k_in = k_ff;
      e_in = e_ff;
      sum_in = sum_ff;
      kerr_in = kerr_ff;
      eerr_in = eerr_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               if (om_le_zero) begin
                  // Out of domain: fixed answers
                  k_in = ALL_ONES;
                  e_in = om30[33] ? 64'd0 : ONE_Q;
                  kerr_in = 1'b1;
                  eerr_in = om30[33];
                  state_in = ST_DONE;
               end else begin
                  t_in = om_q;
                  kerr_in = 1'b0;
                  eerr_in = 1'b0;
                  state_in = ST_OM1;
                  go_in = 1'b1;
               end
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            if (res.done) begin
               go_in = 1'b1;
               case (state_ff)
                  ST_OM1: begin
                     t_in = res.result;
                     state_in = ST_OM2;
                  end
                  ST_OM2: begin
                     b_in = res.result;
                     a_in = ONE_Q;
                     sum_in = '0;
                     iter_in = '0;
                     state_in = ST_AA;
                  end
                  ST_AA: begin
                     aa_in = res.result;
                     state_in = ST_BB;
                  end
                  ST_BB: begin
                     s_in = aa_ff + res.result;
                     state_in = ST_P;
                  end
                  ST_P: begin
                     p_in = res.result;
                     state_in = ST_Q;
                  end
                  ST_Q: begin
                     sum_in = sum_sat;
                     state_in = ST_AB;
                  end
                  ST_AB: begin
                     t_in = res.result;
                     state_in = ST_ABS;
                  end
                  ST_ABS: begin
                     t_in = res.result >> 1;
                     state_in = ST_R1;
                  end
                  ST_R1: begin
                     t_in = res.result;
                     state_in = ST_R2;
                  end
                  ST_R2: begin
                     b_in = res.result;
                     a_in = a_next;
                     iter_in = iter_ff + 1'b1;
                     state_in = (iter_ff == ITER_W'(ITERATIONS - 1)) ? ST_A2 : ST_AA;
                  end
                  ST_A2: begin
                     t_in = res.result;
                     state_in = ST_DIV;
                  end
                  ST_DIV: begin
                     k_in = res.result;
                     state_in = ST_E;
                  end
                  ST_E: begin
                     e_in = res.result;
                     go_in = 1'b0;
                     state_in = ST_DONE;
                  end
                  default: begin
                     go_in = 1'b0;
                     state_in = ST_IDLE;
                  end
               endcase
            end
         end
      endcase
   end

   // Output register: load on finish, drop on take
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_k_in = rsp_k_ff;
      rsp_e_in = rsp_e_ff;
      rsp_kerr_in = rsp_kerr_ff;
      rsp_eerr_in = rsp_eerr_ff;
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
      if (state_ff == ST_DONE && (!rsp_valid_ff || !rsp_stall)) begin
         rsp_valid_in = 1'b1;
         rsp_k_in = to_out(k_ff);
         rsp_e_in = to_out(e_ff);
         rsp_kerr_in = kerr_ff;
         rsp_eerr_in = eerr_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         go_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         go_ff <= go_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      iter_ff <= iter_in;
      a_ff <= a_in;
      b_ff <= b_in;
      aa_ff <= aa_in;
      s_ff <= s_in;
      p_ff <= p_in;
      t_ff <= t_in;
      k_ff <= k_in;
      e_ff <= e_in;
      sum_ff <= sum_in;
      kerr_ff <= kerr_in;
      eerr_ff <= eerr_in;
      rsp_k_ff <= rsp_k_in;
      rsp_e_ff <= rsp_e_in;
      rsp_kerr_ff <= rsp_kerr_in;
      rsp_eerr_ff <= rsp_eerr_in;
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_k_value = rsp_k_ff;
   assign rsp_e_value = rsp_e_ff;
   assign rsp_k_domain_error = rsp_kerr_ff;
   assign rsp_e_domain_error = rsp_eerr_ff;

   // An E domain error implies a K domain error
   a_flags: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (!rsp_e_domain_error || rsp_k_domain_error))
      else $error("E flag without K flag");

   // The unit reports only while a computing state waits for it
   a_done_state: assert property (@(posedge clock) disable iff (reset)
      res.done |-> (state_ff != ST_IDLE && state_ff != ST_DONE))
      else $error("unit done outside a computing state");

   // A start is a single-cycle pulse
   a_go_pulse: assert property (@(posedge clock) disable iff (reset)
      go_ff |=> !go_ff)
      else $error("start held for two cycles");

   // A K domain error always carries a saturated K
   a_kerr_sat: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_k_domain_error) |-> (rsp_k_value == 32'hFFFF_FFFF))
      else $error("K not saturated on domain error");

endmodule
